/* rtl/maf_pkg.sv */
// shared constants and controller/datapath interface types for the moving average filter
`timescale 1ns / 1ps
`default_nettype none

package maf_pkg;

    // default store depth and sample width
    localparam int MAF_DEPTH        = 64;
    localparam int MAF_SAMPLE_WIDTH = 16;

    // window length register
    localparam int         CFG_W     = 7;
    localparam logic [6:0] CFG_RESET = 7'd64;

    // operation codes
    localparam logic OP_FILTER  = 1'b0;
    localparam logic OP_PRELOAD = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;       // latch sample and window length on input transfer
        logic clear_step;   // write one zero entry of the clearing sweep
        logic fill_step;    // write one entry of the preload sweep
        logic read;         // read the entry under the write pointer
        logic update;       // update running sum, store sample, advance pointer
        logic div_start;    // load the divider with the running sum
        logic take_quot;    // capture the saturated quotient as the result
        logic take_sample;  // capture the preload sample as the result
        logic load_out;     // move the result into the output register
    } t_maf_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic sweep_last;   // sweep is at the last entry
        logic div_done;     // quotient is ready
    } t_maf_status;

endpackage

`default_nettype wire

/* rtl/moving_average_filter.sv */
// Boxcar moving average filter: ring of recent samples, running sum, iterative divide.
// Filter item: read the entry under the pointer, update sum and ring, then divide;
// the divider gives one bit per cycle. Input ready stays low until the result is loaded.
// Preload item: the sweep writes one entry a cycle, the sample within the window, zero beyond.
// Reset (synchronous, active low) clears pointer and sum, then a clearing pass
// zeroes the ring with input ready low; window length resets to 64.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_filter
    import maf_pkg::*;
#(
    parameter int DEPTH        = MAF_DEPTH,
    parameter int SAMPLE_WIDTH = MAF_SAMPLE_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic        [CFG_W-1:0]        i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_operation,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed      [SAMPLE_WIDTH-1:0] o_average
);

    t_maf_cmd    w_cmd;
    t_maf_status w_status;
    logic        w_cfg_we;

    // configuration register is always writable
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;

    // controller
    maf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // datapath
    maf_datapath #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_cfg_we   (w_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_sample),
        .o_average  (o_average)
    );

`ifndef SYNTH
    // no second transfer straight after an input transfer
    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    // clearing pass holds off input in the first cycle after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_in_ready)
        else $error("input ready during clearing pass");

    // the divider only finishes while an item is in progress
    a_div_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.div_done |-> !o_in_ready)
        else $error("divider finished while idle");
`endif

endmodule

`default_nettype wire

/* rtl/maf_div.sv */
// iterative restoring divider: signed running sum by window length, saturated to sample range
`timescale 1ns / 1ps
`default_nettype none

module maf_div
    import maf_pkg::*;
#(
    parameter int SUM_W        = 22,
    parameter int LEN_W        = 7,
    parameter int SAMPLE_WIDTH = MAF_SAMPLE_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic signed [SUM_W-1:0]        i_dividend,
    input  wire logic        [LEN_W-1:0]        i_divisor,
    output logic                                o_done,
    output logic signed      [SAMPLE_WIDTH-1:0] o_quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0] r_count;
    logic             r_done;
    logic             r_neg;
    logic [SUM_W-1:0] r_quot;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] r_div;

    logic [LEN_W:0]   w_trial;
    logic [LEN_W:0]   w_diff;
    logic             w_ge;
    logic [SUM_W-1:0] w_mag;
    logic [SUM_W-1:0] w_neg_quot;
    logic [SUM_W-1:0] w_lim_pos;
    logic [SUM_W-1:0] w_lim_neg;

    // one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_quot[SUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    // magnitude of the dividend
    assign w_mag = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;

    // step counter and done flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_count <= CNT_W'(SUM_W);
            end else if (r_count != '0) begin
                r_count <= r_count - 1'b1;
                if (r_count == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_dividend[SUM_W-1];
            r_quot <= w_mag;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_count != '0) begin
            r_quot <= {r_quot[SUM_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[LEN_W-1:0] : w_trial[LEN_W-1:0];
        end
    end

    // sign and saturation
    assign w_lim_pos  = {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    assign w_lim_neg  = w_lim_pos + 1'b1;
    assign w_neg_quot = ~r_quot + 1'b1;

    always_comb begin
        if (r_neg) begin
            if (r_quot > w_lim_neg) begin
                o_quotient = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            end else begin
                o_quotient = w_neg_quot[SAMPLE_WIDTH-1:0];
            end
        end else begin
            if (r_quot > w_lim_pos) begin
                o_quotient = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            end else begin
                o_quotient = r_quot[SAMPLE_WIDTH-1:0];
            end
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

/* rtl/maf_datapath.sv */
// datapath: sample ring, write pointer, running sum, divider and result registers
`timescale 1ns / 1ps
`default_nettype none

module maf_datapath
    import maf_pkg::*;
#(
    parameter int DEPTH        = MAF_DEPTH,
    parameter int SAMPLE_WIDTH = MAF_SAMPLE_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_maf_cmd                       i_cmd,
    output t_maf_status                         o_status,
    input  wire logic                           i_cfg_we,
    input  wire logic        [CFG_W-1:0]        i_cfg_data,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic signed      [SAMPLE_WIDTH-1:0] o_average
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W = PTR_W + 1;
    localparam int SUM_W = SAMPLE_WIDTH + PTR_W;
    localparam int CMP_W = (CFG_W > LEN_W) ? CFG_W : LEN_W;

    logic        [CFG_W-1:0]        r_window_length;
    logic        [PTR_W-1:0]        r_ptr;
    logic        [PTR_W-1:0]        r_addr;
    logic signed [SUM_W-1:0]        r_sum;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic        [LEN_W-1:0]        r_len;
    logic        [SAMPLE_WIDTH-1:0] r_rd_data;
    logic signed [SAMPLE_WIDTH-1:0] r_result;
    logic signed [SAMPLE_WIDTH-1:0] r_average;
    logic        [SAMPLE_WIDTH-1:0] r_ring [DEPTH];

    logic        [CMP_W-1:0]              w_cfg_ext;
    logic        [CMP_W-1:0]              w_eff_len;
    logic                                 w_sweep_last;
    logic        [PTR_W-1:0]              w_addr_next;
    logic        [LEN_W-1:0]              w_ptr_inc;
    logic        [PTR_W-1:0]              w_ptr_next;
    logic signed [SUM_W-1:0]              w_old_ext;
    logic signed [SUM_W-1:0]              w_new_ext;
    logic signed [SAMPLE_WIDTH+LEN_W:0]   w_prod;
    logic                                 w_wr_en;
    logic        [PTR_W-1:0]              w_wr_addr;
    logic        [SAMPLE_WIDTH-1:0]       w_wr_data;
    logic                                 w_div_done;
    logic signed [SAMPLE_WIDTH-1:0]       w_quot;

    // effective window length: zero means one, above the depth means the depth
    always_comb begin
        w_cfg_ext = CMP_W'(r_window_length);
        if (w_cfg_ext == '0) begin
            w_eff_len = CMP_W'(1);
        end else if (w_cfg_ext > CMP_W'(DEPTH)) begin
            w_eff_len = CMP_W'(DEPTH);
        end else begin
            w_eff_len = w_cfg_ext;
        end
    end

    // sweep address and pointer arithmetic
    assign w_sweep_last = (r_addr == PTR_W'(DEPTH - 1));
    assign w_addr_next  = w_sweep_last ? '0 : r_addr + 1'b1;
    assign w_ptr_inc    = {1'b0, r_ptr} + 1'b1;
    assign w_ptr_next   = (w_ptr_inc >= r_len) ? '0 : w_ptr_inc[PTR_W-1:0];

    // sign-extended samples and preload sum
    assign w_old_ext = {{PTR_W{r_rd_data[SAMPLE_WIDTH-1]}}, r_rd_data};
    assign w_new_ext = {{PTR_W{r_sample[SAMPLE_WIDTH-1]}}, r_sample};
    assign w_prod    = r_sample * $signed({1'b0, r_len});

    // ring write port
    always_comb begin
        w_wr_en   = i_cmd.clear_step | i_cmd.fill_step | i_cmd.update;
        w_wr_addr = i_cmd.update ? r_ptr : r_addr;
        if (i_cmd.update) begin
            w_wr_data = r_sample;
        end else if (i_cmd.clear_step || ({1'b0, r_addr} >= r_len)) begin
            w_wr_data = '0;
        end else begin
            w_wr_data = r_sample;
        end
    end

    // sample ring
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ring[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= r_ring[r_ptr];
        end
    end

    // window length register, pointer, sweep address and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= CFG_RESET;
            r_ptr           <= '0;
            r_addr          <= '0;
            r_sum           <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window_length <= i_cfg_data;
            end
            if (i_cmd.clear_step) begin
                r_addr <= w_addr_next;
                r_ptr  <= '0;
                r_sum  <= '0;
            end else if (i_cmd.fill_step) begin
                r_addr <= w_addr_next;
                r_ptr  <= '0;
                r_sum  <= w_prod[SUM_W-1:0];
            end else if (i_cmd.update) begin
                r_ptr <= w_ptr_next;
                r_sum <= r_sum - w_old_ext + w_new_ext;
            end
        end
    end

    // latch the item on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
            r_len    <= w_eff_len[LEN_W-1:0];
        end
    end

    // divider
    maf_div #(
        .SUM_W        (SUM_W),
        .LEN_W        (LEN_W),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_len),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // result and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_quot) begin
            r_result <= w_quot;
        end else if (i_cmd.take_sample) begin
            r_result <= r_sample;
        end
        if (i_cmd.load_out) begin
            r_average <= r_result;
        end
    end

    assign o_status.sweep_last = w_sweep_last;
    assign o_status.div_done   = w_div_done;
    assign o_average           = r_average;

endmodule

`default_nettype wire

/* rtl/maf_ctrl.sv */
// controller: sequences clearing, filtering, preload and output transfer
`timescale 1ns / 1ps
`default_nettype none

module maf_ctrl
    import maf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_operation,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_maf_cmd         o_cmd,
    input  wire t_maf_status i_status
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_READ   = 8'b0000_0100,
        S_UPDATE = 8'b0000_1000,
        S_DSTART = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_FILL   = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = (i_operation == OP_PRELOAD) ? S_FILL : S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.take_quot = 1'b1;
                    n_state         = S_FINISH;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.sweep_last) begin
                    o_cmd.take_sample = 1'b1;
                    n_state           = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
